// ===== sv/ccl_pkg.sv =====
package ccl_pkg;

    // Angle codes: 2^ANGLE_BITS codes per full turn
    localparam int ANGLE_BITS = 16;
    // Trig values are Q2.30
    localparam int TRIG_BITS  = 30;
    localparam int MAG_W      = TRIG_BITS + 1;
    localparam int WIDE_W     = 64;
    // Quotient bits kept; larger quotients clamp to all ones
    localparam int QUO_W      = 33;

    // Odd Taylor terms of sin(pi/2 * x), Q30
    localparam int HORNER_TERMS = 7;
    localparam logic [MAG_W-1:0] SIN_COEF [HORNER_TERMS] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
        31'd172272, 31'd3864, 31'd61
    };

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [31:0] RADIUS_RST = 32'd52428800;
    localparam logic [31:0] HEIGHT_RST = 32'd65536000;

    typedef struct packed {
        logic [MAG_W-1:0] acc;
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] x2;
        logic             neg;
    } t_horner;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } t_trig;

    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] res;
    } t_root;

    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [MAG_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } t_div;

endpackage

// ===== sv/ccl_horner_cell.sv =====
// One Horner step: acc = coef - (acc * x2) >> 30
module ccl_horner_cell #(
    parameter int COEF_IDX = 0
) (
    input  logic             i_clk,
    input  ccl_pkg::t_horner i_word,
    output ccl_pkg::t_horner o_word
);

    logic [2*ccl_pkg::MAG_W-1:0] w_prod;
    logic [ccl_pkg::MAG_W-1:0]   w_step;
    ccl_pkg::t_horner            r_word;

    assign w_prod = i_word.acc * i_word.x2;
    assign w_step = w_prod[ccl_pkg::TRIG_BITS +: ccl_pkg::MAG_W];

    always_ff @(posedge i_clk) begin
        r_word.acc <= ccl_pkg::SIN_COEF[COEF_IDX] - w_step;
        r_word.x   <= i_word.x;
        r_word.x2  <= i_word.x2;
        r_word.neg <= i_word.neg;
    end

    assign o_word = r_word;

endmodule

// ===== sv/ccl_sin.sv =====
// sin of an angle code, Q1.30 magnitude plus sign
module ccl_sin (
    input  logic                            i_clk,
    input  logic [ccl_pkg::ANGLE_BITS-1:0]  i_code,
    output ccl_pkg::t_trig                  o_val
);

    localparam int MW       = ccl_pkg::MAG_W;
    localparam int TB       = ccl_pkg::TRIG_BITS;
    localparam int QUAD_LSB = ccl_pkg::ANGLE_BITS - 2;
    localparam int NT       = ccl_pkg::HORNER_TERMS;
    localparam logic [MW-1:0] ONE = MW'(1) << TB;

    logic [1:0]        w_quad;
    logic [MW-1:0]     w_frac;
    logic [MW-1:0]     w_x;
    logic [2*MW-1:0]   w_sq;
    logic [2*MW-1:0]   w_fin;
    logic [MW-1:0]     w_m;
    ccl_pkg::t_horner  r_head;
    ccl_pkg::t_horner  w_chain [0:NT-1];
    ccl_pkg::t_trig    r_out;

    assign w_quad = i_code[ccl_pkg::ANGLE_BITS-1 -: 2];
    assign w_frac = {1'b0, i_code[QUAD_LSB-1:0], {(TB-QUAD_LSB){1'b0}}};
    // odd quadrants run the quarter wave backwards
    assign w_x    = w_quad[0] ? (ONE - w_frac) : w_frac;
    assign w_sq   = w_x * w_x;

    always_ff @(posedge i_clk) begin
        r_head.acc <= ccl_pkg::SIN_COEF[NT-1];
        r_head.x   <= w_x;
        r_head.x2  <= w_sq[TB +: MW];
        r_head.neg <= w_quad[1];
    end

    assign w_chain[0] = r_head;

    for (genvar j = 0; j < NT - 1; j++) begin : g_cell
        ccl_horner_cell #(
            .COEF_IDX (NT - 2 - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_word (w_chain[j]),
            .o_word (w_chain[j+1])
        );
    end

    assign w_fin = w_chain[NT-1].acc * w_chain[NT-1].x;
    assign w_m   = w_fin[TB +: MW];

    always_ff @(posedge i_clk) begin
        r_out.mag <= (w_m > ONE) ? ONE : w_m;
        r_out.neg <= w_chain[NT-1].neg;
    end

    assign o_val = r_out;

endmodule

// ===== sv/ccl_root_cell.sv =====
// One step of the bit-pair integer square root
module ccl_root_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  ccl_pkg::t_root i_word,
    output ccl_pkg::t_root o_word
);

    localparam int W = ccl_pkg::WIDE_W;
    localparam logic [W-1:0] ONE_W = 1;
    localparam logic [W-1:0] BIT   = ONE_W << (2 * STEP);

    logic [W:0]     w_trial;
    logic           w_take;
    ccl_pkg::t_root r_word;

    assign w_trial = {1'b0, i_word.res} + {1'b0, BIT};
    assign w_take  = {1'b0, i_word.rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word.rem <= i_word.rem - w_trial[W-1:0];
            r_word.res <= (i_word.res >> 1) + BIT;
        end else begin
            r_word.rem <= i_word.rem;
            r_word.res <= i_word.res >> 1;
        end
    end

    assign o_word = r_word;

endmodule

// ===== sv/ccl_div_cell.sv =====
// One restoring division step: quotient bit K
module ccl_div_cell #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  ccl_pkg::t_div i_word,
    output ccl_pkg::t_div o_word
);

    localparam int W  = ccl_pkg::WIDE_W;
    localparam int QW = ccl_pkg::QUO_W;
    localparam logic [QW-1:0] QBIT = QW'(1) << K;

    logic [W-1:0]  w_sh;
    logic          w_take;
    ccl_pkg::t_div r_word;

    assign w_sh   = {{(W-ccl_pkg::MAG_W){1'b0}}, i_word.den} << K;
    assign w_take = i_word.rem >= w_sh;

    always_ff @(posedge i_clk) begin
        r_word.rem <= w_take ? (i_word.rem - w_sh) : i_word.rem;
        r_word.den <= i_word.den;
        r_word.quo <= w_take ? (i_word.quo | QBIT) : i_word.quo;
    end

    assign o_word = r_word;

endmodule

// ===== sv/cylinder_chord_length.sv =====
// Chord length through a point inside an upright cylinder centred at the origin.
//
// Input: a word (pos_x/y/z in signed Q16.16 m, zenith and azimuth as 16-bit
// turn fractions) is taken at a rising edge where start is high and busy is
// low. busy is high only while reset is applied and for the edge after it;
// otherwise the block takes a new word every cycle.
// Output: o_valid is high for exactly one cycle with o_chord_length (unsigned
// Q16.16, saturating) and o_inside_volume. The receiver cannot stall; no
// word is held back.
// Throughput: one word per cycle. The depth is set by the chain of cells: the
// sine polynomial cells, 32 square-root cells and 33 division cells per lane,
// plus registered stages around them.
// Config: write radius (index 0) and height (index 1) through i_cfg_* while
// no word is in flight; other indexes are ignored.
// Reset (synchronous, active low) empties the pipe and restores the
// default radius of 800 m and height of 1000 m.
module cylinder_chord_length (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [31:0]                  i_pos_x,
    input  logic signed [31:0]                  i_pos_y,
    input  logic signed [31:0]                  i_pos_z,
    input  logic [15:0]                         i_zenith_angle,
    input  logic [15:0]                         i_azimuth_angle,
    input  logic                                i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [31:0]                         i_cfg_wdata,
    output logic                                o_valid,
    output logic [31:0]                         o_chord_length,
    output logic                                o_inside_volume
);

    localparam int MW  = ccl_pkg::MAG_W;
    localparam int TB  = ccl_pkg::TRIG_BITS;
    localparam int W   = ccl_pkg::WIDE_W;
    localparam int QW  = ccl_pkg::QUO_W;
    localparam int MDW = 33;          // rounded horizontal offset
    localparam int RUNW = 34;         // runs and cap distances

    // Stage numbers (register stage holding the value)
    localparam int ST_TRIG    = 8;    // sine units deliver here
    localparam int ST_DIR     = 9;
    localparam int ST_MD      = 11;
    localparam int ST_SQ      = 12;
    localparam int ROOT_STEPS = 32;
    localparam int ST_ROOT    = 13 + ROOT_STEPS;
    localparam int ST_RUN     = ST_ROOT + 1;
    localparam int ST_DIVH    = ST_RUN + 1;
    localparam int ST_QUO     = ST_DIVH + QW;
    localparam int ST_MIN     = ST_QUO + 1;
    localparam int ST_OUT     = ST_MIN + 1;

    localparam int LANES   = 4;
    localparam int LANE_TF = 0;       // forward wall run / sin
    localparam int LANE_TB = 1;       // backward wall run / sin
    localparam int LANE_VF = 2;       // forward cap run / cos
    localparam int LANE_VB = 3;       // backward cap run / cos

    localparam logic [ccl_pkg::ANGLE_BITS-1:0] QUARTER =
        {2'b01, {(ccl_pkg::ANGLE_BITS - 2){1'b0}}};
    localparam logic [W-1:0] RND_HALF = 64'd1 << (TB - 1);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    // control
    logic               r_busy;
    logic [ST_OUT:1]    r_vld;
    logic               w_acc;
    logic [31:0]        r_radius;
    logic [31:0]        r_height;

    // stage 1
    logic [31:0]        w_ax, w_ay, w_az;
    logic [W-1:0]       r_ax2, r_ay2, r_r2;
    logic               r_outz;
    t_pos               r_pos [1:ST_TRIG];

    // stage 2 and delay lines
    logic [W-1:0]       w_p2;
    logic               n_inside;
    logic [ST_MIN:2]    r_inside;
    logic [W-1:0]       r_rp [2:ST_SQ];

    // trig
    ccl_pkg::t_trig     w_zs, w_zc, w_as, w_ac;

    // stage 9
    logic signed [31:0] w_ac_s, w_as_s, w_ux, w_uy;
    logic signed [34:0] w_z2, w_h, w_up, w_dn;
    logic [RUNW-1:0]    w_upc, w_dnc;
    logic               w_cpos;
    logic signed [W-1:0] r_px, r_py;
    logic [MW-1:0]      r_s [ST_DIR:ST_RUN];
    logic [MW-1:0]      r_c [ST_DIR:ST_RUN];
    logic [RUNW-1:0]    r_capf [ST_DIR:ST_RUN];
    logic [RUNW-1:0]    r_capb [ST_DIR:ST_RUN];
    logic [ST_MIN:ST_DIR] r_szero;
    logic [ST_QUO:ST_DIR] r_cnz;

    // stages 10 to 13
    logic signed [W-1:0] r_dot;
    logic [W-1:0]       w_adot, w_rnd;
    logic               n_dneg;
    logic [MDW-1:0]     r_md [ST_MD:ST_ROOT];
    logic [ST_ROOT:ST_MD] r_dneg;
    logic [2*MDW-1:0]   w_d2;
    logic [W-1:0]       r_d2;
    logic [W:0]         w_disc_sum;
    ccl_pkg::t_root     r_root;
    ccl_pkg::t_root     w_root [0:ROOT_STEPS];

    // stage 46
    logic signed [34:0] w_q, w_m, w_sum, w_dif, w_fh, w_bh;
    logic [RUNW-1:0]    r_fh, r_bh;

    // divisions
    logic [W-1:0]       w_dvd [LANES];
    logic [MW-1:0]      w_den [LANES];
    ccl_pkg::t_div      r_head [LANES];
    ccl_pkg::t_div      w_div [LANES][0:QW];

    // merge and output
    logic [QW-1:0]      r_tf, r_tb;
    logic [QW:0]        w_len_sum;
    logic [31:0]        w_len;
    logic [31:0]        r_len;
    logic               r_in_out;

    //------------------------------------------------------------------
    // Control and configuration
    //------------------------------------------------------------------
    assign w_acc = start & ~r_busy;
    assign busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_vld    <= '0;
            r_radius <= ccl_pkg::RADIUS_RST;
            r_height <= ccl_pkg::HEIGHT_RST;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[ST_OUT-1:1], w_acc};
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ccl_pkg::REG_RADIUS: r_radius <= i_cfg_wdata;
                    ccl_pkg::REG_HEIGHT: r_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 1: squares and the cap test
    //------------------------------------------------------------------
    assign w_ax = i_pos_x[31] ? -i_pos_x : i_pos_x;
    assign w_ay = i_pos_y[31] ? -i_pos_y : i_pos_y;
    assign w_az = i_pos_z[31] ? -i_pos_z : i_pos_z;

    always_ff @(posedge i_clk) begin
        r_ax2     <= w_ax * w_ax;
        r_ay2     <= w_ay * w_ay;
        r_r2      <= r_radius * r_radius;
        r_outz    <= {w_az, 1'b0} > {1'b0, r_height};
        r_pos[1]  <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        for (int k = 2; k <= ST_TRIG; k++) begin
            r_pos[k] <= r_pos[k-1];
        end
    end

    //------------------------------------------------------------------
    // Stage 2: radial test, inside flag
    //------------------------------------------------------------------
    assign w_p2     = r_ax2 + r_ay2;
    assign n_inside = ~r_outz & (w_p2 <= r_r2);

    always_ff @(posedge i_clk) begin
        r_inside <= {r_inside[ST_MIN-1:2], n_inside};
        r_rp[2]  <= r_r2 - w_p2;
        for (int k = 3; k <= ST_SQ; k++) begin
            r_rp[k] <= r_rp[k-1];
        end
    end

    //------------------------------------------------------------------
    // Sine units; cos(a) = sin(a + quarter turn)
    //------------------------------------------------------------------
    ccl_sin u_zen_sin (.i_clk(i_clk), .i_code(i_zenith_angle),            .o_val(w_zs));
    ccl_sin u_zen_cos (.i_clk(i_clk), .i_code(i_zenith_angle + QUARTER),  .o_val(w_zc));
    ccl_sin u_azi_sin (.i_clk(i_clk), .i_code(i_azimuth_angle),           .o_val(w_as));
    ccl_sin u_azi_cos (.i_clk(i_clk), .i_code(i_azimuth_angle + QUARTER), .o_val(w_ac));

    //------------------------------------------------------------------
    // Stage 9: direction products and cap runs
    //------------------------------------------------------------------
    // a negative zenith sine turns the horizontal direction around
    assign w_ac_s = {1'b0, w_ac.mag};
    assign w_as_s = {1'b0, w_as.mag};
    assign w_ux   = (w_ac.neg ^ w_zs.neg) ? -w_ac_s : w_ac_s;
    assign w_uy   = (w_as.neg ^ w_zs.neg) ? -w_as_s : w_as_s;

    assign w_z2  = {{2{r_pos[ST_TRIG].z[31]}}, r_pos[ST_TRIG].z, 1'b0};
    assign w_h   = {3'b000, r_height};
    assign w_up  = w_h - w_z2;
    assign w_dn  = w_h + w_z2;
    assign w_upc = w_up[34] ? '0 : w_up[RUNW-1:0];
    assign w_dnc = w_dn[34] ? '0 : w_dn[RUNW-1:0];
    assign w_cpos = ~w_zc.neg & (w_zc.mag != '0);

    always_ff @(posedge i_clk) begin
        r_px         <= w_ux * $signed(r_pos[ST_TRIG].x);
        r_py         <= w_uy * $signed(r_pos[ST_TRIG].y);
        r_s[ST_DIR]  <= w_zs.mag;
        r_c[ST_DIR]  <= w_zc.mag;
        r_capf[ST_DIR] <= w_cpos ? w_upc : w_dnc;
        r_capb[ST_DIR] <= w_cpos ? w_dnc : w_upc;
        for (int k = ST_DIR + 1; k <= ST_RUN; k++) begin
            r_s[k]    <= r_s[k-1];
            r_c[k]    <= r_c[k-1];
            r_capf[k] <= r_capf[k-1];
            r_capb[k] <= r_capb[k-1];
        end
        r_szero <= {r_szero[ST_MIN-1:ST_DIR], (w_zs.mag == '0)};
        r_cnz   <= {r_cnz[ST_QUO-1:ST_DIR], (w_zc.mag != '0)};
    end

    //------------------------------------------------------------------
    // Stages 10 to 13: offset d, d^2, discriminant
    //------------------------------------------------------------------
    assign w_adot = r_dot[W-1] ? -r_dot : r_dot;
    assign w_rnd  = w_adot + RND_HALF;
    assign n_dneg = ~r_dot[W-1] & (r_dot != '0);   // d = -md when dot > 0
    assign w_d2   = r_md[ST_MD] * r_md[ST_MD];
    assign w_disc_sum = {1'b0, r_d2} + {1'b0, r_rp[ST_SQ]};

    always_ff @(posedge i_clk) begin
        r_dot       <= r_px + r_py;
        r_md[ST_MD] <= w_rnd[TB +: MDW];
        for (int k = ST_MD + 1; k <= ST_ROOT; k++) begin
            r_md[k] <= r_md[k-1];
        end
        r_dneg <= {r_dneg[ST_ROOT-1:ST_MD], n_dneg};
        r_d2   <= w_d2[W-1:0];
        // saturate on carry out
        r_root.rem <= w_disc_sum[W] ? '1 : w_disc_sum[W-1:0];
        r_root.res <= '0;
    end

    //------------------------------------------------------------------
    // Square root chain
    //------------------------------------------------------------------
    assign w_root[0] = r_root;

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        ccl_root_cell #(
            .STEP (ROOT_STEPS - 1 - j)
        ) u_root (
            .i_clk  (i_clk),
            .i_word (w_root[j]),
            .o_word (w_root[j+1])
        );
    end

    //------------------------------------------------------------------
    // Stage 46: horizontal runs forward and backward
    //------------------------------------------------------------------
    assign w_q   = {3'b000, w_root[ROOT_STEPS].res[31:0]};
    assign w_m   = {2'b00, r_md[ST_ROOT]};
    assign w_sum = w_q + w_m;
    assign w_dif = w_q - w_m;
    assign w_fh  = r_dneg[ST_ROOT] ? w_dif : w_sum;
    assign w_bh  = r_dneg[ST_ROOT] ? w_sum : w_dif;

    always_ff @(posedge i_clk) begin
        r_fh <= w_fh[34] ? '0 : w_fh[RUNW-1:0];
        r_bh <= w_bh[34] ? '0 : w_bh[RUNW-1:0];
    end

    //------------------------------------------------------------------
    // Stage 47: division heads; quotients of 2^33 or more clamp to all ones
    //------------------------------------------------------------------
    assign w_dvd[LANE_TF] = {r_fh, {TB{1'b0}}};
    assign w_dvd[LANE_TB] = {r_bh, {TB{1'b0}}};
    assign w_dvd[LANE_VF] = {1'b0, r_capf[ST_RUN], {(TB-1){1'b0}}};
    assign w_dvd[LANE_VB] = {1'b0, r_capb[ST_RUN], {(TB-1){1'b0}}};
    assign w_den[LANE_TF] = r_s[ST_RUN];
    assign w_den[LANE_TB] = r_s[ST_RUN];
    assign w_den[LANE_VF] = r_c[ST_RUN];
    assign w_den[LANE_VB] = r_c[ST_RUN];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_head[l].rem <= w_dvd[l];
            r_head[l].den <= w_den[l];
            r_head[l].quo <= (w_dvd[l] >= {w_den[l], {QW{1'b0}}}) ? '1 : '0;
        end

        assign w_div[l][0] = r_head[l];

        for (genvar j = 0; j < QW; j++) begin : g_div
            ccl_div_cell #(
                .K (QW - 1 - j)
            ) u_div (
                .i_clk  (i_clk),
                .i_word (w_div[l][j]),
                .o_word (w_div[l][j+1])
            );
        end
    end

    //------------------------------------------------------------------
    // Stage 81: cap limits; stage 82: sum, saturate, special cases
    //------------------------------------------------------------------
    assign w_len_sum = {1'b0, r_tf} + {1'b0, r_tb};
    assign w_len     = (w_len_sum[QW:32] != '0) ? 32'hFFFF_FFFF : w_len_sum[31:0];

    always_ff @(posedge i_clk) begin
        r_tf <= (r_cnz[ST_QUO] && (w_div[LANE_VF][QW].quo < w_div[LANE_TF][QW].quo))
              ? w_div[LANE_VF][QW].quo : w_div[LANE_TF][QW].quo;
        r_tb <= (r_cnz[ST_QUO] && (w_div[LANE_VB][QW].quo < w_div[LANE_TB][QW].quo))
              ? w_div[LANE_VB][QW].quo : w_div[LANE_TB][QW].quo;

        if (!r_inside[ST_MIN]) begin
            r_len <= '0;
        end else if (r_szero[ST_MIN]) begin
            r_len <= r_height;       // vertical: full height
        end else begin
            r_len <= w_len;
        end
        r_in_out <= r_inside[ST_MIN];
    end

    assign o_valid         = r_vld[ST_OUT];
    assign o_chord_length  = r_len;
    assign o_inside_volume = r_in_out;

endmodule
